### hw/rtl/afs_pkg.sv
// Shared types and constants of the frame sequencer.
// No dependencies; every other file of the block but afs_rsp_if uses it.
package afs_pkg;

   localparam int DIV_W       = 17;  // signed divider width
   localparam int PERIOD_W    = 15;  // frame period register width
   localparam int STEP_W      = 2;
   localparam int SEQ_MODE_W  = 2;
   localparam int OP_W        = 2;
   localparam int DATA_W      = 8;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET   = PERIOD_W'(14915);
   localparam logic [DIV_W-1:0]    DIV_RESET      = DIV_W'(1);
   localparam logic [DIV_W-1:0]    TICK_DECREMENT = DIV_W'(2);

   // frame mode register bits
   localparam int CTRL_FIVE_STEP_BIT = 7;
   localparam int CTRL_IRQ_CLR_BIT   = 6;

   // register index, taken from paddr bit 2 (registers are 4 bytes apart)
   typedef enum logic [0:0] {
      REG_FRAME_PERIOD = 1'b0
   } reg_index_type;

   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]   mode;
      logic [DATA_W-1:0] data;
   } req_payload_type;

   typedef struct packed {
      logic quarter_strobe;
      logic half_strobe;
      logic irq_line;
      logic status_irq;
   } rsp_payload_type;

   // handshake between the input register and the sequencer core
   typedef struct packed {
      logic            valid;
      req_payload_type payload;
   } stage_req_type;

endpackage

### hw/rtl/afs_req_if.sv
// Request channel of the frame sequencer: valid/ready plus the request fields.
// Depends on afs_pkg for field widths.
interface afs_req_if;
   logic                       valid;
   logic                       ready;
   logic [afs_pkg::OP_W-1:0]   mode;
   logic [afs_pkg::DATA_W-1:0] data;

   modport source (output valid, output mode, output data, input ready);
   modport sink   (input valid, input mode, input data, output ready);
endinterface

### hw/rtl/afs_rsp_if.sv
// Result channel of the frame sequencer: valid/ready plus the result fields.
// No package dependency.
interface afs_rsp_if;
   logic valid;
   logic ready;
   logic quarter_strobe;
   logic half_strobe;
   logic irq_line;
   logic status_irq;

   modport source (output valid, output quarter_strobe, output half_strobe,
                   output irq_line, output status_irq, input ready);
   modport sink   (input valid, input quarter_strobe, input half_strobe,
                   input irq_line, input status_irq, output ready);
endinterface

### hw/rtl/afs_csr.sv
// APB-style register file holding the frame period.
// Depends on afs_pkg.
module afs_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [afs_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [afs_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [afs_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   output logic [afs_pkg::PERIOD_W-1:0]      frame_period
);
   import afs_pkg::*;

   logic [PERIOD_W-1:0] period_ff;
   logic [PERIOD_W-1:0] period_in;
   logic                wr_hit;
   reg_index_type       reg_idx;

   assign reg_idx = reg_index_type'(paddr[2]);
   assign wr_hit  = psel && penable && pwrite && (reg_idx == REG_FRAME_PERIOD);

   always_comb begin
      period_in = period_ff;
      if (wr_hit) begin
         period_in = pwdata[PERIOD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else begin
         period_ff <= period_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_idx == REG_FRAME_PERIOD) begin
         prdata = CSR_DATA_W'(period_ff);
      end
   end

   assign pready       = 1'b1;
   assign frame_period = period_ff;
endmodule

### hw/rtl/afs_in_stage.sv
// Input register of the frame sequencer: captures one request per cycle while it is empty or its request moves on.
// Depends on afs_pkg and afs_req_if.
module afs_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   afs_req_if.sink                req_bus,
   input  logic                   take,
   output afs_pkg::stage_req_type stage_out
);
   import afs_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   req_payload_type payload_ff;
   req_payload_type payload_in;
   logic            load;

   // room when empty or when the held request moves on this cycle
   assign req_bus.ready = !valid_ff || take;
   assign load          = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in   = valid_ff;
      payload_in = payload_ff;
      if (load) begin
         valid_in        = 1'b1;
         payload_in.mode = req_bus.mode;
         payload_in.data = req_bus.data;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
   end

   assign stage_out.valid   = valid_ff;
   assign stage_out.payload = payload_ff;
endmodule

### hw/rtl/afs_core.sv
// Sequencer state, per-request update logic and the result register.
// Depends on afs_pkg and afs_rsp_if.
module afs_core (
   input  logic                          clock,
   input  logic                          reset,
   input  afs_pkg::stage_req_type        stage_in,
   input  logic [afs_pkg::PERIOD_W-1:0]  frame_period,
   output logic                          take,
   afs_rsp_if.source                     rsp_bus
);
   import afs_pkg::*;

   logic [DIV_W-1:0]      div_ff, div_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [SEQ_MODE_W-1:0] seq_mode_ff, seq_mode_in;
   logic                  irq_ff, irq_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_ff, rsp_in;

   logic [DIV_W-1:0]      div_dec;
   logic [DIV_W-1:0]      div_addend;
   logic [STEP_W-1:0]     step_next;
   logic                  fire;
   logic                  wrap;
   logic [DATA_W-1:0]     wdata;
   op_type                op;
   rsp_payload_type       res;

   assign take = stage_in.valid && (!rsp_valid_ff || rsp_bus.ready);

   assign op        = op_type'(stage_in.payload.mode);
   assign wdata     = stage_in.payload.data;
   assign div_dec   = div_ff - TICK_DECREMENT;
   assign fire      = (div_dec == '0) || div_dec[DIV_W-1];
   assign step_next = step_ff + STEP_W'(1);
   assign wrap      = (step_next == '0);
   // five-step wrap reloads the period twice
   assign div_addend = (wrap && seq_mode_ff[1]) ? {1'b0, frame_period, 1'b0}
                                                : {2'b00, frame_period};

   always_comb begin
      div_in      = div_ff;
      step_in     = step_ff;
      seq_mode_in = seq_mode_ff;
      irq_in      = irq_ff;
      res         = '0;
      case (op)
         OP_TICK: begin
            div_in = div_dec;
            if (fire) begin
               step_in           = step_next;
               res.quarter_strobe = 1'b1;
               res.half_strobe    = step_next[0];
               div_in            = div_dec + div_addend;
               if (wrap && (seq_mode_ff == '0)) begin
                  irq_in = 1'b1;
               end
            end
         end
         OP_WRITE: begin
            seq_mode_in = wdata[CTRL_FIVE_STEP_BIT:CTRL_IRQ_CLR_BIT];
            step_in     = '0;
            if (wdata[CTRL_FIVE_STEP_BIT]) begin
               // immediate step from count zero: odd count, both strobes
               step_in            = STEP_W'(1);
               res.quarter_strobe = 1'b1;
               res.half_strobe    = 1'b1;
            end
            if (wdata[CTRL_IRQ_CLR_BIT]) begin
               irq_in = 1'b0;
            end
            div_in = {2'b00, frame_period};
         end
         OP_READ: begin
            res.status_irq = irq_ff;
            irq_in         = 1'b0;
         end
         default: begin
         end
      endcase
      res.irq_line = irq_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff       <= DIV_RESET;
         step_ff      <= '0;
         seq_mode_ff  <= '0;
         irq_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            div_ff      <= div_in;
            step_ff     <= step_in;
            seq_mode_ff <= seq_mode_in;
            irq_ff      <= irq_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.quarter_strobe = rsp_ff.quarter_strobe;
   assign rsp_bus.half_strobe    = rsp_ff.half_strobe;
   assign rsp_bus.irq_line       = rsp_ff.irq_line;
   assign rsp_bus.status_irq     = rsp_ff.status_irq;
endmodule

### hw/rtl/apu_frame_sequencer_unit.sv
// Frame sequencer of a sound unit: top level.
// Depends on afs_pkg, afs_req_if, afs_rsp_if, afs_csr, afs_in_stage, afs_core.
//
// Usage:
//   req_bus carries one request per handshake: mode 0 ticks the divider by
//   one sound-unit cycle, mode 1 writes the frame mode register from data,
//   mode 2 reads status (returns and clears the frame interrupt flag); mode
//   3 leaves all state untouched. Each request yields exactly one result on
//   rsp_bus with the quarter and half strobes, the interrupt flag after the
//   request and, for a status read, the flag as it was before the read.
//   The APB port holds frame_period at byte address 0; write it only while
//   no request is in flight.
// Timing:
//   The request is registered in the input register when accepted, and its
//   result is registered in the result register when the core takes it. The
//   unit accepts one request per cycle while rsp_bus.ready stays high; the
//   state update (a 17-bit subtract, compare and add) is combinational.
// Reset (synchronous, active high): divider loads 1, step count, mode and
//   interrupt flag clear, frame_period returns to 14915, both stages empty.
// Stall: when rsp_bus.ready is low the result holds; the input register
//   still fills, then req_bus.ready drops until the result is taken.
module apu_frame_sequencer_unit (
   input  logic                           clock,
   input  logic                           reset,
   afs_req_if.sink                        req_bus,
   afs_rsp_if.source                      rsp_bus,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [afs_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [afs_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [afs_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import afs_pkg::*;

   logic [PERIOD_W-1:0] frame_period;
   stage_req_type       stage_req;
   logic                take;

   // configuration register
   afs_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .frame_period (frame_period)
   );

   // hold the accepted request until the core takes it
   afs_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .take      (take),
      .stage_out (stage_req)
   );

   // advance the sequencer and register the result
   afs_core u_core (
      .clock        (clock),
      .reset        (reset),
      .stage_in     (stage_req),
      .frame_period (frame_period),
      .take         (take),
      .rsp_bus      (rsp_bus)
   );
endmodule
